FILE: hdl/irps_pkg.sv
package irps_pkg;

  // Ring size in bytes. It must be a multiple of the four-byte word that each event pushes.
  localparam int RingBytes    = 1024;
  localparam int BytesPerWord = 4;
  localparam int IdxW         = $clog2(RingBytes);
  localparam int WordsDepth   = RingBytes / BytesPerWord;
  localparam int AddrW        = IdxW - 2;

  localparam int LenW  = 24;
  localparam int WordW = LenW + 1;

  localparam logic [LenW-1:0] LengthMax      = 24'hFFFFFF;
  localparam logic [31:0]     LongGapSeconds = 32'd15;
  localparam int              MicrosPerSecond = 1000000;

  localparam int CfgIndexW = 2;
  localparam int CfgDataW  = 2;

  typedef enum logic [CfgIndexW-1:0] {
    RegEnable = 2'd0,
    RegSense  = 2'd1
  } cfg_reg_t;

  typedef enum logic {
    OpEvent = 1'b0,
    OpPop   = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ResIdle    = 2'd0,
    ResStored  = 2'd1,
    ResDropped = 2'd2
  } result_t;

  typedef struct packed {
    logic rd_en;
    logic pop;
    logic push;
  } ring_req_t;

  typedef struct packed {
    logic empty;
    logic room;
  } ring_stat_t;

endpackage

FILE: hdl/irps_cmd_if.sv
interface irps_cmd_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic        dcd_level;
  logic [31:0] time_seconds;
  logic [19:0] time_micros;

  modport source (output valid, op, dcd_level, time_seconds, time_micros, input ready);
  modport sink (input valid, op, dcd_level, time_seconds, time_micros, output ready);
endinterface

FILE: hdl/irps_rsp_if.sv
interface irps_rsp_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        byte_valid;
  logic [1:0]  event_result;
  logic [24:0] event_word;
  logic        sense_now;

  modport source (output valid, data_byte, byte_valid, event_result, event_word, sense_now,
                  input ready);
  modport sink (input valid, data_byte, byte_valid, event_result, event_word, sense_now,
                output ready);
endinterface

FILE: hdl/irps_ring.sv
module irps_ring (
  input  logic                          clk,
  input  logic                          rst,
  input  irps_pkg::ring_req_t           req,
  input  logic [irps_pkg::WordW-1:0]    push_word,
  output irps_pkg::ring_stat_t          stat,
  output logic [7:0]                    rd_byte
);

  logic [irps_pkg::IdxW-1:0]  read_index;
  logic [irps_pkg::IdxW-1:0]  write_index;
  logic [irps_pkg::IdxW-1:0]  read_index_next;
  logic [irps_pkg::IdxW-1:0]  write_index_next;
  logic [irps_pkg::IdxW:0]    used;
  logic [irps_pkg::WordW-1:0] mem [irps_pkg::WordsDepth];
  logic [irps_pkg::WordW-1:0] rd_word;
  logic [1:0]                 rd_lane;

  // Words are always pushed whole, so the write index stays word aligned
  // and each push is a single write of one memory row.
  always_comb begin
    if (write_index >= read_index) begin
      used = {1'b0, write_index} - {1'b0, read_index};
    end else begin
      used = {1'b0, write_index} + (irps_pkg::IdxW+1)'(irps_pkg::RingBytes)
             - {1'b0, read_index};
    end
    stat.empty = (read_index == write_index);
    stat.room  = (used <= (irps_pkg::IdxW+1)'(irps_pkg::RingBytes - 1 - irps_pkg::BytesPerWord));

    read_index_next = (read_index == irps_pkg::IdxW'(irps_pkg::RingBytes - 1)) ? '0
                      : read_index + 1'b1;
    write_index_next = (write_index >= irps_pkg::IdxW'(irps_pkg::RingBytes - irps_pkg::BytesPerWord))
                       ? '0 : write_index + irps_pkg::IdxW'(irps_pkg::BytesPerWord);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      read_index  <= '0;
      write_index <= '0;
    end else begin
      if (req.pop) begin
        read_index <= read_index_next;
      end
      if (req.push) begin
        write_index <= write_index_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.push) begin
      mem[write_index[irps_pkg::IdxW-1:2]] <= push_word;
    end
    if (req.rd_en) begin
      rd_word <= mem[read_index[irps_pkg::IdxW-1:2]];
      rd_lane <= read_index[1:0];
    end
  end

  // The top byte of a word carries only the pulse bit.
  always_comb begin
    case (rd_lane)
      2'd0:    rd_byte = rd_word[7:0];
      2'd1:    rd_byte = rd_word[15:8];
      2'd2:    rd_byte = rd_word[23:16];
      default: rd_byte = {7'b0, rd_word[24]};
    endcase
  end

endmodule

FILE: hdl/ir_pulse_space_capture_fifo.sv
// Infrared pulse/space capture with a byte ring.
// The cmd channel takes one item per handshake: either a level-change event
// stamped with seconds and microseconds, or a request to pop one byte. The
// rsp channel returns exactly one result item for each command item.
// An enabled event with known sense measures the time since the last recorded
// event, forms a 25-bit pulse/space word and pushes it as four bytes, low byte
// first, into a 1024-byte ring as one word-wide write; it is dropped when fewer
// than four bytes are free. A pop returns the oldest byte.
// The input register is loaded at acceptance and the result register once it is
// free, with the ring read registered alongside the result.
// Throughput is one item per cycle while rsp is not stalled; the ring has one
// word write and one word read port and each item uses at most one of them.
// The user must write configuration (cfg_we, cfg_index, cfg_data) only while the
// block is idle; the block does not enforce it. Reset clears both ring indices,
// the last timestamp and the enable, and sets the sense to unknown; ring contents
// are not cleared and need no sweep. When rsp is stalled the result register
// holds, one more item is taken into the input register, and then cmd.ready
// drops until rsp drains.
module ir_pulse_space_capture_fifo (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [irps_pkg::CfgIndexW-1:0]    cfg_index,
  input  logic [irps_pkg::CfgDataW-1:0]     cfg_data,
  irps_cmd_if.sink                          cmd,
  irps_rsp_if.source                        rsp
);

  logic        s1_valid;
  logic        s1_op;
  logic        s1_dcd;
  logic [31:0] s1_secs;
  logic [19:0] s1_micros;

  logic                        s2_valid;
  logic                        s2_byte_valid;
  logic [1:0]                  s2_result;
  logic [irps_pkg::WordW-1:0]  s2_word;
  logic                        s2_sense;

  logic        receiver_enable;
  logic [1:0]  sense_setting;
  logic        polarity;
  logic [31:0] last_seconds;
  logic [19:0] last_micros;

  logic                        s2_load;
  logic                        accept_evt;
  logic                        is_pop;
  logic [31:0]                 dsec;
  logic                        long_gap;
  logic [irps_pkg::LenW-1:0]   sec_us;
  logic signed [irps_pkg::LenW+1:0] diff;
  logic [irps_pkg::LenW-1:0]   short_len;
  logic [irps_pkg::LenW-1:0]   length;
  logic                        pol_new;
  logic                        pulse;
  logic [irps_pkg::WordW-1:0]  word;

  irps_pkg::ring_req_t  ring_req;
  irps_pkg::ring_stat_t ring_stat;
  logic [7:0]           rd_byte;

  assign s2_load   = s1_valid && (!s2_valid || rsp.ready);
  assign cmd.ready = !s1_valid || s2_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd.valid && cmd.ready) begin
      s1_valid <= 1'b1;
    end else if (s2_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      s1_op     <= cmd.op;
      s1_dcd    <= cmd.dcd_level;
      s1_secs   <= cmd.time_seconds;
      s1_micros <= cmd.time_micros;
    end
  end

  // Gap measurement. Within the short window the seconds difference is at
  // most 15, so the product fits in 24 bits and the signed sum in 26.
  always_comb begin
    is_pop     = (s1_op == irps_pkg::OpPop);
    accept_evt = !is_pop && receiver_enable && !sense_setting[1];
    dsec       = s1_secs - last_seconds;
    long_gap   = (dsec > irps_pkg::LongGapSeconds);
    sec_us     = irps_pkg::LenW'(dsec[3:0]) * irps_pkg::LenW'(irps_pkg::MicrosPerSecond);
    diff       = $signed({2'b00, sec_us}) + $signed({6'b0, s1_micros})
                 - $signed({6'b0, last_micros});
    if (diff < 0) begin
      short_len = '0;
    end else if (diff > $signed({2'b00, irps_pkg::LengthMax})) begin
      short_len = irps_pkg::LengthMax;
    end else begin
      short_len = diff[irps_pkg::LenW-1:0];
    end
    // A long gap must end in a space; if the level reads as a pulse the sense is wrong.
    pol_new = polarity ^ (long_gap && (s1_dcd == polarity));
    length  = long_gap ? irps_pkg::LengthMax : short_len;
    pulse   = (s1_dcd == pol_new);
    word    = {pulse, length};
  end

  always_comb begin
    ring_req.rd_en = s2_load && is_pop;
    ring_req.pop   = s2_load && is_pop && !ring_stat.empty;
    ring_req.push  = s2_load && accept_evt && ring_stat.room;
  end

  irps_ring u_ring (
    .clk       (clk),
    .rst       (rst),
    .req       (ring_req),
    .push_word (word),
    .stat      (ring_stat),
    .rd_byte   (rd_byte)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      receiver_enable <= 1'b0;
      sense_setting   <= 2'd2;
      polarity        <= 1'b0;
      last_seconds    <= '0;
      last_micros     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        irps_pkg::RegEnable: begin
          receiver_enable <= cfg_data[0];
        end
        irps_pkg::RegSense: begin
          sense_setting <= cfg_data;
          polarity      <= cfg_data[1] ? 1'b0 : cfg_data[0];
        end
        default: begin
        end
      endcase
    end else if (s2_load && accept_evt) begin
      polarity     <= pol_new;
      last_seconds <= s1_secs;
      last_micros  <= s1_micros;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_load) begin
      s2_valid <= 1'b1;
    end else if (rsp.ready) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_byte_valid <= is_pop && !ring_stat.empty;
      if (accept_evt) begin
        s2_result <= ring_stat.room ? irps_pkg::ResStored : irps_pkg::ResDropped;
        s2_word   <= word;
        s2_sense  <= pol_new;
      end else begin
        s2_result <= irps_pkg::ResIdle;
        s2_word   <= '0;
        s2_sense  <= polarity;
      end
    end
  end

  assign rsp.valid        = s2_valid;
  assign rsp.data_byte    = s2_byte_valid ? rd_byte : 8'd0;
  assign rsp.byte_valid   = s2_byte_valid;
  assign rsp.event_result = s2_result;
  assign rsp.event_word   = s2_word;
  assign rsp.sense_now    = s2_sense;

`ifndef SYNTHESIS
  a_ring_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(ring_req.push && ring_req.pop))
    else $error("ring push and pop in the same cycle");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    ring_req.push |-> ring_stat.room)
    else $error("ring push without four free bytes");

  a_push_fills: assert property (@(posedge clk) disable iff (rst)
    ring_req.push |=> !ring_stat.empty)
    else $error("ring empty right after a push");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s2_valid && !rsp.ready) |-> !cmd.ready)
    else $error("input taken while both stages are full and stalled");

  a_pop_result: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.byte_valid) |-> (rsp.event_result == irps_pkg::ResIdle
                                       && rsp.event_word == '0))
    else $error("popped byte carries an event result");
`endif

endmodule
